### design/isi_pkg.sv
// shared widths, register indexes and stage payload types for the im2col index generator
`default_nettype none

package isi_pkg;

  localparam int COL_W    = 16;
  localparam int ROW_W    = 16;
  localparam int BATCH_W  = 8;
  localparam int SX_W     = 17;
  localparam int SY_W     = 21;
  localparam int CHAN_W   = 16;
  localparam int CFG_W    = 12;
  localparam int CFG_IDX_W = 2;
  localparam int SMALL_W  = 4;
  localparam int AREA_W   = 8;
  localparam int OWID_W   = 12;
  localparam int PX_W     = 16;
  localparam int PY_W     = 20;

  localparam logic [CFG_IDX_W-1:0] REG_PADDING      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SIZE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_WIDTH = 2'd3;

  typedef struct packed {
    logic [SMALL_W-1:0] padding;
    logic [SMALL_W-1:0] stride;
    logic [SMALL_W-1:0] kernel;
    logic [AREA_W-1:0]  area;
    logic [OWID_W-1:0]  width;
  } cfg_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  chan;
    logic [BATCH_W-1:0] batch;
    logic [PX_W-1:0]    px;
    logic [PY_W-1:0]    py;
  } mid_t;

endpackage

`default_nettype wire

### design/isi_cfg.sv
// configuration registers with zero-size fixups and precomputed kernel area
`default_nettype none

module isi_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [isi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [isi_pkg::CFG_W-1:0]     cfg_data,
  output isi_pkg::cfg_t                      cfg
);
  import isi_pkg::*;

  logic [SMALL_W-1:0] k_eff;
  logic [OWID_W-1:0]  w_eff;
  logic [AREA_W-1:0]  area_next;

  // a zero kernel or width behaves as one
  assign k_eff = (cfg_data[SMALL_W-1:0] == '0) ? SMALL_W'(1) : cfg_data[SMALL_W-1:0];
  assign w_eff = (cfg_data[OWID_W-1:0] == '0) ? OWID_W'(1) : cfg_data[OWID_W-1:0];
  assign area_next = AREA_W'({4'b0, k_eff} * {4'b0, k_eff});

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.padding <= SMALL_W'(0);
      cfg.stride  <= SMALL_W'(1);
      cfg.kernel  <= SMALL_W'(3);
      cfg.area    <= AREA_W'(9);
      cfg.width   <= OWID_W'(28);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PADDING:      cfg.padding <= cfg_data[SMALL_W-1:0];
        REG_STRIDE:       cfg.stride  <= cfg_data[SMALL_W-1:0];
        REG_KERNEL_SIZE: begin
          cfg.kernel <= k_eff;
          cfg.area   <= area_next;
        end
        REG_OUTPUT_WIDTH: cfg.width   <= w_eff;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### design/isi_divider.sv
// pipelined restoring divider, a fixed number of quotient bits per stage
`default_nettype none

module isi_divider #(
  parameter int W      = 16,
  parameter int D      = 12,
  parameter int STAGES = 4
) (
  input  wire logic              clk,
  input  wire logic [STAGES-1:0] en,
  input  wire logic [W-1:0]      dividend,
  input  wire logic [D-1:0]      divisor,
  output logic      [W-1:0]      quotient,
  output logic      [D-1:0]      remainder
);

  localparam int B = W / STAGES;

  logic [D-1:0] rem      [STAGES];
  logic [W-1:0] work     [STAGES];
  logic [D-1:0] rem_next [STAGES];
  logic [W-1:0] work_next[STAGES];

  // work holds the unconsumed dividend bits on top and the quotient bits below
  always_comb begin
    logic [D-1:0] r;
    logic [W-1:0] w;
    logic [D:0]   trial;
    for (int s = 0; s < STAGES; s++) begin
      r = (s == 0) ? '0 : rem[(s == 0) ? 0 : s-1];
      w = (s == 0) ? dividend : work[(s == 0) ? 0 : s-1];
      for (int b = 0; b < B; b++) begin
        trial = {r, w[W-1]};
        w = {w[W-2:0], 1'b0};
        if (trial >= {1'b0, divisor}) begin
          trial = trial - {1'b0, divisor};
          w[0] = 1'b1;
        end
        r = trial[D-1:0];
      end
      rem_next[s]  = r;
      work_next[s] = w;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < STAGES; s++) begin
      if (en[s]) begin
        rem[s]  <= rem_next[s];
        work[s] <= work_next[s];
      end
    end
  end

  assign quotient  = work[STAGES-1];
  assign remainder = rem[STAGES-1];

endmodule

`default_nettype wire

### design/im2col_source_index.sv
// top level: im2col source coordinate pipeline
// Takes one request per cycle while the output side does not stall and presents
// source_x, source_y, channel and batch from the registers of stage seven. Stages one
// to four run two restoring dividers side by side (column by output width, row by
// kernel area), four quotient bits per stage; stages five and six split the patch
// offset by the kernel size while the stride products are formed; stage seven adds
// the kernel offset and subtracts padding. Every stage holds its own valid bit, so
// bubbles are squeezed out and a stall at the output loses nothing. Configuration
// writes take effect at once and are meant to happen while the pipeline is empty.
`default_nettype none

module im2col_source_index (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [isi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [isi_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [isi_pkg::COL_W-1:0]     column_index,
  input  wire logic [isi_pkg::ROW_W-1:0]     row_index,
  input  wire logic [isi_pkg::BATCH_W-1:0]   batch_number,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [isi_pkg::SX_W-1:0]    source_x,
  output logic signed [isi_pkg::SY_W-1:0]    source_y,
  output logic      [isi_pkg::CHAN_W-1:0]    channel,
  output logic      [isi_pkg::BATCH_W-1:0]   batch_out
);
  import isi_pkg::*;

  localparam int NSTAGE   = 7;
  localparam int DIV_STG  = 4;
  localparam int OFF_STG  = 2;

  cfg_t cfg;

  logic [NSTAGE-1:0] valid_q;
  logic [NSTAGE:0]   adv;
  logic [BATCH_W-1:0] batch_q [DIV_STG];

  logic [COL_W-1:0]  prow;
  logic [OWID_W-1:0] pcol;
  logic [CHAN_W-1:0] chan;
  logic [AREA_W-1:0] offset;
  logic [AREA_W-1:0] krow;
  logic [SMALL_W-1:0] kcol;

  mid_t mid4, mid5, mid4_next;

  isi_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // a stage may load when it is empty or its contents move on
  always_comb begin
    adv[NSTAGE] = out_ready;
    for (int s = NSTAGE-1; s >= 0; s--) begin
      adv[s] = !valid_q[s] || adv[s+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = valid_q[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= '0;
    end else begin
      for (int s = 0; s < NSTAGE; s++) begin
        if (adv[s]) begin
          valid_q[s] <= (s == 0) ? in_valid : valid_q[(s == 0) ? 0 : s-1];
        end
      end
    end
  end

  isi_divider #(.W(COL_W), .D(OWID_W), .STAGES(DIV_STG)) u_col_div (
    .clk       (clk),
    .en        (adv[DIV_STG-1:0]),
    .dividend  (column_index),
    .divisor   (cfg.width),
    .quotient  (prow),
    .remainder (pcol)
  );

  isi_divider #(.W(ROW_W), .D(AREA_W), .STAGES(DIV_STG)) u_row_div (
    .clk       (clk),
    .en        (adv[DIV_STG-1:0]),
    .dividend  (row_index),
    .divisor   (cfg.area),
    .quotient  (chan),
    .remainder (offset)
  );

  isi_divider #(.W(AREA_W), .D(SMALL_W), .STAGES(OFF_STG)) u_off_div (
    .clk       (clk),
    .en        (adv[DIV_STG+OFF_STG-1:DIV_STG]),
    .dividend  (offset),
    .divisor   (cfg.kernel),
    .quotient  (krow),
    .remainder (kcol)
  );

  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_STG; s++) begin
      if (adv[s]) begin
        batch_q[s] <= (s == 0) ? batch_number : batch_q[(s == 0) ? 0 : s-1];
      end
    end
  end

  // stride products
  always_comb begin
    mid4_next.chan  = chan;
    mid4_next.batch = batch_q[DIV_STG-1];
    mid4_next.px    = PX_W'({4'b0, pcol} * {12'b0, cfg.stride});
    mid4_next.py    = PY_W'({4'b0, prow} * {16'b0, cfg.stride});
  end

  always_ff @(posedge clk) begin
    if (adv[DIV_STG]) begin
      mid4 <= mid4_next;
    end
    if (adv[DIV_STG+1]) begin
      mid5 <= mid4;
    end
    if (adv[NSTAGE-1]) begin
      source_x  <= $signed({1'b0, mid5.px}) - $signed({13'b0, cfg.padding})
                 + $signed({13'b0, kcol});
      source_y  <= $signed({1'b0, mid5.py}) - $signed({17'b0, cfg.padding})
                 + $signed({17'b0, krow[SMALL_W-1:0]});
      channel   <= mid5.chan;
      batch_out <= mid5.batch;
    end
  end

  // a pipeline with an empty last stage always has room for a request
  a_room_when_drained: assert property (@(posedge clk) disable iff (rst)
    !valid_q[NSTAGE-1] |-> in_ready)
    else $error("in_ready low with empty output stage");

  // an accepted request is held in the first stage on the next cycle
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> valid_q[0])
    else $error("accepted request lost at stage one");

  // padding can pull coordinates at most fifteen below zero
  a_coord_floor: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (source_x >= -17'sd15) && (source_y >= -21'sd15))
    else $error("source coordinate below padding floor");

endmodule

`default_nettype wire
